// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrp assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrp assertion failed");

`endif

// ===== design/mrp_pkg.sv =====
// Shared types and constants of the modem response parser.
`default_nettype none
package mrp_pkg;

  localparam int PREFIX_DEPTH = 12;

  localparam int DEF_LINE_LIMIT   = 256;
  localparam int DEF_CONTENT_ROWS = 16;
  localparam int DEF_CONTENT_COLS = 32;
  localparam int DEF_MESSAGE_ROWS = 64;
  localparam int DEF_MESSAGE_COLS = 64;

  typedef logic [7:0] prefix_t [PREFIX_DEPTH];

  typedef struct packed {
    logic httpaction;
    logic httpread;
    logic creg;
    logic cgatt;
    logic csq;
    logic cmgr;
    logic echo;
    logic alive;
  } key_hits_t;

  typedef enum logic [3:0] {
    EV_ALIVE       = 4'd0,
    EV_REG_MODE    = 4'd1,
    EV_REG_STATUS  = 4'd2,
    EV_ATTACH      = 4'd3,
    EV_SIGNAL      = 4'd4,
    EV_READ_REQ    = 4'd5,
    EV_CONTENT_CHR = 4'd6,
    EV_CONTENT_END = 4'd7,
    EV_PHONE_CHR   = 4'd8,
    EV_SMS_CHR     = 4'd9,
    EV_SMS_END     = 4'd10
  } event_code_t;

endpackage
`default_nettype wire

// ===== design/mrp_key_match.sv =====
// Compares the start of the current line against the fixed line keys.
`default_nettype none
module mrp_key_match import mrp_pkg::*; #(
  parameter int POS_W = 8
) (
  input  wire prefix_t          prefix,
  input  wire logic [POS_W-1:0] pos,
  output key_hits_t             hits
);

  localparam prefix_t KEY_HTTPACTION = '{"+", "H", "T", "T", "P", "A", "C", "T", "I", "O",
                                         "N", ":"};
  localparam prefix_t KEY_HTTPREAD   = '{"+", "H", "T", "T", "P", "R", "E", "A", "D", ":",
                                         8'h00, 8'h00};
  localparam prefix_t KEY_CREG       = '{"+", "C", "R", "E", "G", ":", 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00};
  localparam prefix_t KEY_CGATT      = '{"+", "C", "G", "A", "T", "T", ":", 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00};
  localparam prefix_t KEY_CSQ        = '{"+", "C", "S", "Q", ":", 8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00};
  localparam prefix_t KEY_CMGR       = '{"+", "C", "M", "G", "R", ":", 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00};
  localparam prefix_t KEY_ECHO       = '{"A", "T", "+", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 8'h00};
  localparam prefix_t KEY_ALIVE      = '{"A", "T", 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 8'h00};

  // Only the first len bytes take part in the compare.
  function automatic logic bytes_match(prefix_t p, prefix_t k, int unsigned len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < PREFIX_DEPTH; i++) begin
      if (i < len && p[i] != k[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  assign hits.httpaction = (pos == POS_W'(12)) && bytes_match(prefix, KEY_HTTPACTION, 12);
  assign hits.httpread   = (pos == POS_W'(10)) && bytes_match(prefix, KEY_HTTPREAD, 10);
  assign hits.creg       = (pos == POS_W'(6))  && bytes_match(prefix, KEY_CREG, 6);
  assign hits.cgatt      = (pos == POS_W'(7))  && bytes_match(prefix, KEY_CGATT, 7);
  assign hits.csq        = (pos == POS_W'(5))  && bytes_match(prefix, KEY_CSQ, 5);
  assign hits.cmgr       = (pos == POS_W'(6))  && bytes_match(prefix, KEY_CMGR, 6);
  assign hits.echo       = (pos == POS_W'(3))  && bytes_match(prefix, KEY_ECHO, 3);
  assign hits.alive      = (pos == POS_W'(3))  && bytes_match(prefix, KEY_ALIVE, 3);

endmodule
`default_nettype wire

// ===== design/modem_response_parser_unit.sv =====
// A result beat appears on the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; the parse state and counters update in a single pass.
// A byte is refused only while a result beat is held by a stalled output.
// Reset (synchronous, active low) returns to key detection with an empty line,
// cleared counters and no result pending.
`default_nettype none
module modem_response_parser_unit import mrp_pkg::*; #(
  parameter int LINE_LIMIT   = DEF_LINE_LIMIT,
  parameter int CONTENT_ROWS = DEF_CONTENT_ROWS,
  parameter int CONTENT_COLS = DEF_CONTENT_COLS,
  parameter int MESSAGE_ROWS = DEF_MESSAGE_ROWS,
  parameter int MESSAGE_COLS = DEF_MESSAGE_COLS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_event_code,
  output logic [15:0]      out_value,
  output logic [5:0]       out_row,
  output logic [5:0]       out_col
);

  localparam int POS_W = $clog2(LINE_LIMIT);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [4:0] {
    S_DETECT, S_CHECK_STA, S_CHECK_OK, S_ECHO,
    S_HA_TYPE, S_HA_RESULT, S_HA_LEN, S_HA_LEN_TAIL,
    S_HR_LEN, S_HR_CONTENT, S_HR_ROWFULL, S_HR_OVER,
    S_CREG_N, S_CREG_STAT, S_CGATT,
    S_CSQ_SPACE, S_CSQ, S_CSQ_TAIL,
    S_CMGR_READ, S_CMGR_PHONE, S_CMGR_PHONE_FULL, S_CMGR_DATE,
    S_CMGR_MSG, S_CMGR_ROWFULL, S_CMGR_OVER
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  prefix_t          prefix_r, prefix_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [5:0]       crow_r, crow_nxt, ccol_r, ccol_nxt;
  logic [5:0]       phone_r, phone_nxt;
  logic [5:0]       mrow_r, mrow_nxt, mcol_r, mcol_nxt;
  logic             out_valid_r, out_valid_nxt;
  event_code_t      out_code_r, out_code_nxt;
  logic [15:0]      out_value_r, out_value_nxt;
  logic [5:0]       out_row_r, out_row_nxt, out_col_r, out_col_nxt;

  logic             in_fire;
  logic [7:0]       b;
  logic [POS_W:0]   pos_inc;
  logic [POS_W-1:0] pos1;
  prefix_t          p1;
  key_hits_t        hits;
  logic             clr;
  logic             is_digit;
  logic [19:0]      acc_sum;
  logic [15:0]      acc_add;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign b        = in_rx_byte;

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign acc_sum  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'h0000, b[3:0]};
  assign acc_add  = (acc_sum > 20'd65535) ? 16'hFFFF : acc_sum[15:0];

  // The byte is placed in the line buffer before any key is compared.
  always_comb begin
    p1      = prefix_r;
    pos_inc = {1'b0, pos_r} + (POS_W+1)'(1);
    for (int i = 0; i < PREFIX_DEPTH; i++) begin
      if (pos_r == POS_W'(i)) p1[i] = b;
    end
    pos1 = pos_inc[POS_W-1:0];
    if (pos_inc >= (POS_W+1)'(LINE_LIMIT)) begin
      pos1 = '0;
      for (int i = 0; i < PREFIX_DEPTH; i++) p1[i] = 8'h00;
    end
  end

  mrp_key_match #(.POS_W(POS_W)) u_key_match (
    .prefix (p1),
    .pos    (pos1),
    .hits   (hits)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    prefix_nxt    = prefix_r;
    acc_nxt       = acc_r;
    crow_nxt      = crow_r;
    ccol_nxt      = ccol_r;
    phone_nxt     = phone_r;
    mrow_nxt      = mrow_r;
    mcol_nxt      = mcol_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    out_value_nxt = out_value_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    clr           = 1'b0;

    if (in_fire) begin
      out_valid_nxt = 1'b0;
      out_code_nxt  = EV_ALIVE;
      out_value_nxt = 16'h0000;
      out_row_nxt   = 6'd0;
      out_col_nxt   = 6'd0;

      unique case (state_r)
        S_DETECT: begin
          if (b == CH_LF) begin
            clr = 1'b1;
          end else begin
            if (hits.echo) begin
              state_nxt = S_ECHO;
            end else if (b == CH_COLON) begin
              if (hits.httpaction)    state_nxt = S_HA_TYPE;
              else if (hits.httpread) state_nxt = S_HR_LEN;
              else if (hits.creg)     state_nxt = S_CREG_N;
              else if (hits.cgatt)    state_nxt = S_CGATT;
              else if (hits.csq)      state_nxt = S_CSQ_SPACE;
              else if (hits.cmgr)     state_nxt = S_CMGR_READ;
              clr = 1'b1;
            end
            if (hits.alive) state_nxt = S_CHECK_STA;
          end
        end
        S_CHECK_STA: begin
          if (b == CH_LF) begin
            state_nxt     = S_CHECK_OK;
            clr           = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
        S_CHECK_OK, S_ECHO: begin
          if (b == CH_LF) begin
            state_nxt = S_DETECT;
            clr       = 1'b1;
          end
        end
        S_HA_TYPE: begin
          if (b == CH_COMMA) begin
            state_nxt = S_HA_RESULT;
            clr       = 1'b1;
          end
        end
        S_HA_RESULT: begin
          if (b == CH_COMMA) begin
            state_nxt = S_HA_LEN;
            clr       = 1'b1;
            acc_nxt   = 16'h0000;
          end
        end
        S_HA_LEN, S_HA_LEN_TAIL: begin
          if (b == CH_LF) begin
            state_nxt     = S_DETECT;
            clr           = 1'b1;
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_READ_REQ;
            out_value_nxt = acc_r;
          end else if (state_r == S_HA_LEN) begin
            if (is_digit) acc_nxt = acc_add;
            else          state_nxt = S_HA_LEN_TAIL;
          end
        end
        S_HR_LEN: begin
          if (b == CH_LF) begin
            state_nxt = S_HR_CONTENT;
            clr       = 1'b1;
          end
        end
        S_HR_CONTENT, S_HR_ROWFULL, S_HR_OVER: begin
          if (b == CH_LF) begin
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_CONTENT_END;
            out_row_nxt   = crow_r;
            if (state_r == S_HR_CONTENT)      out_value_nxt = {10'd0, ccol_r};
            else if (state_r == S_HR_ROWFULL) out_value_nxt = 16'({1'b0, ccol_r} + 7'd1);
            crow_nxt  = 6'd0;
            ccol_nxt  = 6'd0;
            state_nxt = S_DETECT;
            clr       = 1'b1;
          end else if (state_r != S_HR_OVER && b != CH_CR) begin
            if (b == CH_COMMA) begin
              ccol_nxt = 6'd0;
              if (({1'b0, crow_r} + 7'd1) < 7'(CONTENT_ROWS)) begin
                crow_nxt  = crow_r + 6'd1;
                state_nxt = S_HR_CONTENT;
              end else begin
                state_nxt = S_HR_OVER;
              end
            end else if (state_r != S_HR_ROWFULL) begin
              out_valid_nxt = 1'b1;
              out_code_nxt  = EV_CONTENT_CHR;
              out_value_nxt = {8'h00, b};
              out_row_nxt   = crow_r;
              out_col_nxt   = ccol_r;
              if (({1'b0, ccol_r} + 7'd1) >= 7'(CONTENT_COLS)) state_nxt = S_HR_ROWFULL;
              else ccol_nxt = ccol_r + 6'd1;
            end
          end
        end
        S_CREG_N: begin
          if (b == CH_COMMA) begin
            state_nxt     = S_CREG_STAT;
            clr           = 1'b1;
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_REG_MODE;
            out_value_nxt = {8'h00, p1[1]};
          end
        end
        S_CREG_STAT: begin
          if (b == CH_LF) begin
            state_nxt     = S_DETECT;
            clr           = 1'b1;
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_REG_STATUS;
            out_value_nxt = {8'h00, p1[0]};
          end
        end
        S_CGATT: begin
          if (b == CH_LF) begin
            state_nxt     = S_DETECT;
            clr           = 1'b1;
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_ATTACH;
            out_value_nxt = {8'h00, p1[1]};
          end
        end
        S_CSQ_SPACE: begin
          if (b == CH_SPACE) begin
            state_nxt = S_CSQ;
            clr       = 1'b1;
            acc_nxt   = 16'h0000;
          end
        end
        S_CSQ, S_CSQ_TAIL: begin
          if (b == CH_COMMA) begin
            state_nxt     = S_ECHO;
            clr           = 1'b1;
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_SIGNAL;
            out_value_nxt = acc_r;
          end else if (state_r == S_CSQ) begin
            if (is_digit) acc_nxt = acc_add;
            else          state_nxt = S_CSQ_TAIL;
          end
        end
        S_CMGR_READ: begin
          if (b == CH_COMMA) begin
            state_nxt = S_CMGR_PHONE;
            clr       = 1'b1;
            phone_nxt = 6'd0;
          end
        end
        S_CMGR_PHONE, S_CMGR_PHONE_FULL: begin
          if (b == CH_COMMA) begin
            state_nxt = S_CMGR_DATE;
            clr       = 1'b1;
            phone_nxt = 6'd0;
          end else if (state_r == S_CMGR_PHONE) begin
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_PHONE_CHR;
            out_value_nxt = {8'h00, b};
            out_col_nxt   = phone_r;
            if (phone_r == 6'd63) state_nxt = S_CMGR_PHONE_FULL;
            else phone_nxt = phone_r + 6'd1;
          end
        end
        S_CMGR_DATE: begin
          if (b == CH_LF) begin
            state_nxt = S_CMGR_MSG;
            clr       = 1'b1;
          end
        end
        S_CMGR_MSG, S_CMGR_ROWFULL, S_CMGR_OVER: begin
          if (b == CH_LF) begin
            out_valid_nxt = 1'b1;
            out_code_nxt  = EV_SMS_END;
            out_row_nxt   = mrow_r;
            if (state_r == S_CMGR_MSG)          out_value_nxt = {10'd0, mcol_r};
            else if (state_r == S_CMGR_ROWFULL) out_value_nxt = 16'({1'b0, mcol_r} + 7'd1);
            mrow_nxt  = 6'd0;
            mcol_nxt  = 6'd0;
            state_nxt = S_DETECT;
            clr       = 1'b1;
          end else if (state_r != S_CMGR_OVER && b != CH_CR) begin
            if (b == CH_STAR) begin
              mcol_nxt = 6'd0;
              if (({1'b0, mrow_r} + 7'd1) < 7'(MESSAGE_ROWS)) begin
                mrow_nxt  = mrow_r + 6'd1;
                state_nxt = S_CMGR_MSG;
              end else begin
                state_nxt = S_CMGR_OVER;
              end
            end else if (state_r != S_CMGR_ROWFULL) begin
              out_valid_nxt = 1'b1;
              out_code_nxt  = EV_SMS_CHR;
              out_value_nxt = {8'h00, b};
              out_row_nxt   = mrow_r;
              out_col_nxt   = mcol_r;
              if (({1'b0, mcol_r} + 7'd1) >= 7'(MESSAGE_COLS)) state_nxt = S_CMGR_ROWFULL;
              else mcol_nxt = mcol_r + 6'd1;
            end
          end
        end
        default: begin
          state_nxt = S_DETECT;
        end
      endcase

      pos_nxt    = clr ? '0 : pos1;
      prefix_nxt = p1;
      if (clr) begin
        for (int i = 0; i < PREFIX_DEPTH; i++) prefix_nxt[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_DETECT;
      pos_r       <= '0;
      for (int i = 0; i < PREFIX_DEPTH; i++) prefix_r[i] <= 8'h00;
      acc_r       <= 16'h0000;
      crow_r      <= 6'd0;
      ccol_r      <= 6'd0;
      phone_r     <= 6'd0;
      mrow_r      <= 6'd0;
      mcol_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      prefix_r    <= prefix_nxt;
      acc_r       <= acc_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      phone_r     <= phone_nxt;
      mrow_r      <= mrow_nxt;
      mcol_r      <= mcol_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_code_r  <= out_code_nxt;
    out_value_r <= out_value_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;
  assign out_value      = out_value_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;

endmodule
`default_nettype wire

// ===== design/mrp_checker.sv =====
// Port-level checks on the modem response parser, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mrp_checker import mrp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  out_event_code,
  input wire logic [15:0] out_value,
  input wire logic [5:0]  out_row,
  input wire logic [5:0]  out_col
);

  `MRP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_event_code) && $stable(out_value) && $stable(out_row) && $stable(out_col))
  `MRP_ASSERT_IMPL(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)
  `MRP_ASSERT_IMPL(a_code_range, clk, rst_n, out_valid, out_event_code <= EV_SMS_END)
  `MRP_ASSERT_IMPL(a_alive_zero, clk, rst_n, out_valid && out_event_code == EV_ALIVE, out_value == 16'd0 && out_row == 6'd0 && out_col == 6'd0)
  `MRP_ASSERT_IMPL(a_no_pos, clk, rst_n, out_valid && (out_event_code == EV_REG_MODE || out_event_code == EV_REG_STATUS || out_event_code == EV_ATTACH || out_event_code == EV_SIGNAL || out_event_code == EV_READ_REQ), out_row == 6'd0 && out_col == 6'd0)

endmodule

bind modem_response_parser_unit mrp_checker u_mrp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code),
  .out_value      (out_value),
  .out_row        (out_row),
  .out_col        (out_col)
);
`default_nettype wire

// ===== test/modem_response_parser_unit_checker.sv =====
// Checker for the modem response parser: watches both channels, predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module modem_response_parser_unit_checker import mrp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_event_code,
  input  wire logic [15:0] out_value,
  input  wire logic [5:0]  out_row,
  input  wire logic [5:0]  out_col,
  output int               fail_count,
  output int               pending
);

  typedef enum int {
    PS_DETECT, PS_ALIVE_LINE, PS_ALIVE_SKIP, PS_ECHO,
    PS_HA_TYPE, PS_HA_RESULT, PS_HA_LEN, PS_HA_LEN_TAIL,
    PS_HR_LEN, PS_HR_CONTENT, PS_HR_ROWFULL, PS_HR_OVER,
    PS_REG_MODE, PS_REG_STAT, PS_CGATT,
    PS_CSQ_SPACE, PS_CSQ, PS_CSQ_TAIL,
    PS_SMS_STATUS, PS_SMS_NUMBER, PS_SMS_NUMBER_FULL, PS_CMGR_DATE,
    PS_CMGR_MSG, PS_CMGR_ROWFULL, PS_CMGR_OVER
  } parse_state_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] value;
    logic [5:0]  row;
    logic [5:0]  col;
  } parser_event_t;

  parse_state_t  pstate;
  int            line_pos;
  logic [7:0]    line_head [PREFIX_DEPTH];
  int            number;
  int            crow, ccol, phone_idx, mrow, mcol;
  parser_event_t expected_events [$];

  function automatic void clear_line();
    foreach (line_head[i]) line_head[i] = 8'h00;
    line_pos = 0;
  endfunction

  function automatic bit line_equals(string key);
    if (line_pos != key.len()) return 0;
    for (int i = 0; i < key.len(); i++)
      if (line_head[i] != key[i]) return 0;
    return 1;
  endfunction

  function automatic void add_digit(logic [7:0] b);
    number = number * 10 + (b - "0");
    if (number > 65535) number = 65535;
  endfunction

  function automatic void push_event(event_code_t code, int value, int row, int col);
    parser_event_t e;
    e.code = code;
    e.value = value[15:0];
    e.row = row[5:0];
    e.col = col[5:0];
    expected_events.push_back(e);
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    int n;
    if (line_pos < PREFIX_DEPTH) line_head[line_pos] = b;
    line_pos++;
    if (line_pos >= DEF_LINE_LIMIT) clear_line();
    case (pstate)
      PS_DETECT: begin
        if (b == 8'h0a) begin
          clear_line();
        end else begin
          if (line_pos == 3 && line_equals("AT+")) begin
            pstate = PS_ECHO;
          end else if (b == ":") begin
            if (line_equals("+HTTPACTION:")) pstate = PS_HA_TYPE;
            else if (line_equals("+HTTPREAD:")) pstate = PS_HR_LEN;
            else if (line_equals("+CREG:")) pstate = PS_REG_MODE;
            else if (line_equals("+CGATT:")) pstate = PS_CGATT;
            else if (line_equals("+CSQ:")) pstate = PS_CSQ_SPACE;
            else if (line_equals("+CMGR:")) pstate = PS_SMS_STATUS;
            clear_line();
          end
          if (line_pos == 3 && line_equals("AT\r")) pstate = PS_ALIVE_LINE;
        end
      end
      PS_ALIVE_LINE: if (b == 8'h0a) begin
        pstate = PS_ALIVE_SKIP;
        clear_line();
        push_event(EV_ALIVE, 0, 0, 0);
      end
      PS_ALIVE_SKIP, PS_ECHO: if (b == 8'h0a) begin
        pstate = PS_DETECT;
        clear_line();
      end
      PS_HA_TYPE: if (b == ",") begin
        pstate = PS_HA_RESULT;
        clear_line();
      end
      PS_HA_RESULT: if (b == ",") begin
        pstate = PS_HA_LEN;
        clear_line();
        number = 0;
      end
      PS_HA_LEN, PS_HA_LEN_TAIL: begin
        if (b == 8'h0a) begin
          pstate = PS_DETECT;
          clear_line();
          push_event(EV_READ_REQ, number, 0, 0);
        end else if (pstate == PS_HA_LEN) begin
          if (b >= "0" && b <= "9") add_digit(b);
          else pstate = PS_HA_LEN_TAIL;
        end
      end
      PS_HR_LEN: if (b == 8'h0a) begin
        pstate = PS_HR_CONTENT;
        clear_line();
      end
      PS_HR_CONTENT, PS_HR_ROWFULL, PS_HR_OVER: begin
        if (b == 8'h0a) begin
          n = pstate == PS_HR_CONTENT ? ccol : pstate == PS_HR_ROWFULL ? ccol + 1 : 0;
          push_event(EV_CONTENT_END, n, crow, 0);
          crow = 0;
          ccol = 0;
          pstate = PS_DETECT;
          clear_line();
        end else if (pstate != PS_HR_OVER && b != 8'h0d) begin
          if (b == ",") begin
            ccol = 0;
            if (crow + 1 < DEF_CONTENT_ROWS) begin
              crow++;
              pstate = PS_HR_CONTENT;
            end else begin
              pstate = PS_HR_OVER;
            end
          end else if (pstate != PS_HR_ROWFULL) begin
            push_event(EV_CONTENT_CHR, b, crow, ccol);
            if (ccol + 1 >= DEF_CONTENT_COLS) pstate = PS_HR_ROWFULL;
            else ccol++;
          end
        end
      end
      PS_REG_MODE: if (b == ",") begin
        pstate = PS_REG_STAT;
        push_event(EV_REG_MODE, line_head[1], 0, 0);
        clear_line();
      end
      PS_REG_STAT: if (b == 8'h0a) begin
        pstate = PS_DETECT;
        push_event(EV_REG_STATUS, line_head[0], 0, 0);
        clear_line();
      end
      PS_CGATT: if (b == 8'h0a) begin
        pstate = PS_DETECT;
        push_event(EV_ATTACH, line_head[1], 0, 0);
        clear_line();
      end
      PS_CSQ_SPACE: if (b == " ") begin
        pstate = PS_CSQ;
        clear_line();
        number = 0;
      end
      PS_CSQ, PS_CSQ_TAIL: begin
        if (b == ",") begin
          pstate = PS_ECHO;
          clear_line();
          push_event(EV_SIGNAL, number, 0, 0);
        end else if (pstate == PS_CSQ) begin
          if (b >= "0" && b <= "9") add_digit(b);
          else pstate = PS_CSQ_TAIL;
        end
      end
      PS_SMS_STATUS: if (b == ",") begin
        pstate = PS_SMS_NUMBER;
        clear_line();
        phone_idx = 0;
      end
      PS_SMS_NUMBER, PS_SMS_NUMBER_FULL: begin
        if (b == ",") begin
          pstate = PS_CMGR_DATE;
          clear_line();
          phone_idx = 0;
        end else if (pstate != PS_SMS_NUMBER_FULL) begin
          push_event(EV_PHONE_CHR, b, 0, phone_idx);
          if (phone_idx >= 63) pstate = PS_SMS_NUMBER_FULL;
          else phone_idx++;
        end
      end
      PS_CMGR_DATE: if (b == 8'h0a) begin
        pstate = PS_CMGR_MSG;
        clear_line();
      end
      PS_CMGR_MSG, PS_CMGR_ROWFULL, PS_CMGR_OVER: begin
        if (b == 8'h0a) begin
          n = pstate == PS_CMGR_MSG ? mcol : pstate == PS_CMGR_ROWFULL ? mcol + 1 : 0;
          push_event(EV_SMS_END, n, mrow, 0);
          mrow = 0;
          mcol = 0;
          pstate = PS_DETECT;
          clear_line();
        end else if (pstate != PS_CMGR_OVER && b != 8'h0d) begin
          if (b == "*") begin
            mcol = 0;
            if (mrow + 1 < DEF_MESSAGE_ROWS) begin
              mrow++;
              pstate = PS_CMGR_MSG;
            end else begin
              pstate = PS_CMGR_OVER;
            end
          end else if (pstate != PS_CMGR_ROWFULL) begin
            push_event(EV_SMS_CHR, b, mrow, mcol);
            if (mcol + 1 >= DEF_MESSAGE_COLS) pstate = PS_CMGR_ROWFULL;
            else mcol++;
          end
        end
      end
      default: pstate = PS_DETECT;
    endcase
  endfunction

  assign pending = expected_events.size();

  always @(posedge clk) begin
    parser_event_t want;
    if (!rst_n) begin
      pstate = PS_DETECT;
      clear_line();
      number = 0;
      crow = 0;
      ccol = 0;
      phone_idx = 0;
      mrow = 0;
      mcol = 0;
      expected_events.delete();
      fail_count = 0;
    end else begin
      // The result beat of this edge comes from an earlier byte, so compare first.
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: code %0d value %0d row %0d col %0d",
                     out_event_code, out_value, out_row, out_col);
        end else begin
          want = expected_events.pop_front();
          if (want.code != out_event_code || want.value != out_value ||
              want.row != out_row || want.col != out_col) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       want.code, want.value, want.row, want.col,
                       out_event_code, out_value, out_row, out_col);
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(in_rx_byte);
    end
  end

endmodule
`default_nettype wire

// ===== test/modem_response_parser_unit_tb.sv =====
// Testbench top for the modem response parser: stimulus, reset and verdict.
`timescale 1ns / 100ps
`default_nettype none
module modem_response_parser_unit_tb;

  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_event_code;
  logic [15:0] out_value;
  logic [5:0]  out_row;
  logic [5:0]  out_col;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles = 0;
  byte         byte_stream [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modem_response_parser_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_code(out_event_code), .out_value(out_value),
    .out_row(out_row), .out_col(out_col)
  );

  modem_response_parser_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_code(out_event_code), .out_value(out_value),
    .out_row(out_row), .out_col(out_col),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Counts edges with no accepted beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
  endtask

  task automatic add_noise(int count);
    repeat (count) byte_stream.push_back(byte'($urandom_range(255)));
  endtask

  task automatic add_digits(int count);
    repeat (count) byte_stream.push_back(byte'("0" + $urandom_range(9)));
  endtask

  task automatic add_chars(int count, byte splitter);
    repeat (count) begin
      case ($urandom_range(9))
        0: byte_stream.push_back(splitter);
        1: byte_stream.push_back(8'h0d);
        default: byte_stream.push_back(byte'($urandom_range(32, 126)));
      endcase
    end
  endtask

  // Sends the queued bytes; the valid stays high across beats that follow on directly.
  task automatic send_stream();
    while (byte_stream.size() > 0) begin
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_valid <= 1'b1;
        in_rx_byte <= byte_stream.pop_front();
        @(posedge clk);
        while (in_stall) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic add_random_line();
    case ($urandom_range(9))
      0: begin add_text("AT+"); add_noise($urandom_range(6)); add_text("\n"); end
      1: begin add_text("AT\r\nOK\r\n"); end
      2: begin
        add_text("+HTTPACTION: "); add_digits($urandom_range(2)); add_text(",");
        add_digits($urandom_range(3)); add_text(",");
        add_digits($urandom_range(7)); add_noise($urandom_range(2)); add_text("\r\n");
      end
      3: begin
        add_text("+HTTPREAD: "); add_digits(3); add_text("\r\n");
        add_chars($urandom_range(1) ? $urandom_range(50) : $urandom_range(400), ",");
        add_text("\n");
      end
      4: begin
        add_text("+CREG: "); add_digits($urandom_range(2)); add_text(",");
        add_digits($urandom_range(2)); add_text("\n");
      end
      5: begin add_text("+CGATT: "); add_digits($urandom_range(2)); add_text("\n"); end
      6: begin
        add_text("+CSQ:"); add_noise($urandom_range(1)); add_text(" ");
        add_digits($urandom_range(7)); add_noise($urandom_range(1));
        add_text(",99\r\n");
      end
      7: begin
        add_text("+CMGR: \"REC READ\",\""); add_digits($urandom_range(14));
        if ($urandom_range(7) == 0) add_chars(70, "*");
        add_text("\",,\"date\"\r\n");
        add_chars($urandom_range(1) ? $urandom_range(60) : $urandom_range(500), "*");
        add_text("\n");
      end
      default: begin add_noise($urandom_range(20)); add_text("\n"); end
    endcase
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: every key, the alive echo and both row splitters.
    add_text("AT\r\nOK\r\nAT+CSQ\r\n");
    add_text("+CSQ: 99999,0\r\n+CREG: 2,5\n+CGATT: 1\n");
    add_text("+HTTPACTION: 0,200,123\n+HTTPREAD: 4\r\nab,c\r\n");
    add_text("+CMGR: \"R\",\"+84\",,\"d\"\r\nhi*yo\n");
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hff);
    add_text("\n");
    send_stream();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 66 : 36) : 0;
      recv_stall_pct = (phase == 2) ? 66 : (phase == 3 ? 36 : 0);
      repeat (5) begin
        add_random_line();
        send_stream();
      end
      // Hold the sender back until every expected result has drained.
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/mrp_pkg.sv
design/mrp_key_match.sv
design/modem_response_parser_unit.sv
design/mrp_checker.sv
test/modem_response_parser_unit_checker.sv
test/modem_response_parser_unit_tb.sv
